/* hdl/srsw_pkg.sv */
package srsw_pkg;

    // Field widths fixed by the stream format
    localparam int REQ_W     = 2;
    localparam int SEQ_NUM_W = 6;
    localparam int ACT_W     = 2;
    localparam int WIN_W     = 6;
    localparam int WALK_W    = 6;
    localparam int DATA_W    = 8;

    // Defaults and limits
    localparam int                SEQ_SPACE_DEF = 64;
    localparam logic [WIN_W-1:0]  WIN_RESET     = 6'd8;
    localparam logic [WALK_W-1:0] MAX_WALK      = 6'd63;

    // Request kinds carried in the slave-side tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_SEND = 2'd0,
        REQ_ACK  = 2'd1,
        REQ_NACK = 2'd2
    } t_req;

    // Action kinds carried in the master-side tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_GRANT  = 2'd0,
        ACT_REFUSE = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_RETX   = 2'd3
    } t_action;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_SEND,
        DP_NACK,
        DP_MARK,
        DP_BASE,
        DP_WALK
    } t_dp_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        t_req req;
        logic at_base;
        logic walk_more;
    } t_dp_status;

endpackage

/* hdl/srsw_ctrl.sv */
module srsw_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  srsw_pkg::t_dp_status   i_status,
    output srsw_pkg::t_dp_cmd      o_cmd
);

    srsw_pkg::t_state r_state;
    srsw_pkg::t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide the next state and the datapath operation
    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.op        = srsw_pkg::DP_NOP;
        case (r_state)
            srsw_pkg::ST_CLEAR: begin
                o_cmd.op = srsw_pkg::DP_CLEAR;
                if (i_status.clear_done) begin
                    n_state = srsw_pkg::ST_IDLE;
                end
            end
            srsw_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = srsw_pkg::DP_LOAD;
                    n_state  = srsw_pkg::ST_EXEC;
                end
            end
            srsw_pkg::ST_EXEC: begin
                case (i_status.req)
                    srsw_pkg::REQ_SEND: begin
                        if (i_status.out_free) begin
                            o_cmd.op = srsw_pkg::DP_SEND;
                            n_state  = srsw_pkg::ST_IDLE;
                        end
                    end
                    srsw_pkg::REQ_NACK: begin
                        if (i_status.out_free) begin
                            o_cmd.op = srsw_pkg::DP_NACK;
                            n_state  = srsw_pkg::ST_IDLE;
                        end
                    end
                    srsw_pkg::REQ_ACK: begin
                        // ACK at the base starts the walk; its result leaves from the walk
                        if (i_status.at_base) begin
                            o_cmd.op = srsw_pkg::DP_BASE;
                            n_state  = srsw_pkg::ST_WALK;
                        end else if (i_status.out_free) begin
                            o_cmd.op = srsw_pkg::DP_MARK;
                            n_state  = srsw_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        // Unused request kind: drop it
                        n_state = srsw_pkg::ST_IDLE;
                    end
                endcase
            end
            srsw_pkg::ST_WALK: begin
                if (i_status.out_free) begin
                    o_cmd.op = srsw_pkg::DP_WALK;
                    if (!i_status.walk_more) begin
                        n_state = srsw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = srsw_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/srsw_datapath.sv */
module srsw_datapath #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srsw_pkg::t_dp_cmd                  i_cmd,
    output srsw_pkg::t_dp_status               o_status,
    input  logic                               i_cfg_valid,
    input  logic [srsw_pkg::WIN_W-1:0]         i_cfg_data,
    input  logic [srsw_pkg::REQ_W-1:0]         i_in_req,
    input  logic [srsw_pkg::SEQ_NUM_W-1:0]     i_in_seq,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [srsw_pkg::ACT_W-1:0]         o_out_action,
    output logic [srsw_pkg::SEQ_NUM_W-1:0]     o_out_seq,
    output logic                               o_out_last
);

    localparam int SEQ_W = $clog2(SEQ_SPACE);
    localparam int CMP_W = (SEQ_W > srsw_pkg::WIN_W) ? SEQ_W : srsw_pkg::WIN_W;
    localparam int TAB_N = 2 ** srsw_pkg::SEQ_NUM_W;
    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [SEQ_W:0]   SEQ_SPAN = (SEQ_W + 1)'(SEQ_SPACE);
    localparam logic [CMP_W-1:0] WIN_MAX  = CMP_W'(SEQ_SPACE - 1);

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (s == SEQ_LAST) ? '0 : s + SEQ_W'(1);
    endfunction

    function automatic logic [srsw_pkg::SEQ_NUM_W-1:0] seq_out(input logic [SEQ_W-1:0] s);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(s);
        return ext[srsw_pkg::SEQ_NUM_W-1:0];
    endfunction

    // Window state and working registers
    logic [srsw_pkg::WIN_W-1:0]  r_window_size;
    logic [SEQ_W-1:0]            r_base, n_base;
    logic [SEQ_W-1:0]            r_next, n_next;
    logic [SEQ_W-1:0]            r_cur, n_cur;
    logic [SEQ_W-1:0]            r_seq, n_seq;
    logic [SEQ_W-1:0]            r_clr_addr, n_clr_addr;
    logic [srsw_pkg::WALK_W-1:0] r_walked, n_walked;
    srsw_pkg::t_req              r_req, n_req;

    // Acknowledged marks
    logic                        r_marks [SEQ_SPACE];
    logic                        r_rd_mark;
    logic                        w_wr_en;
    logic [SEQ_W-1:0]            w_wr_addr;
    logic                        w_wr_data;

    // Result register
    logic                           r_out_valid, n_out_valid;
    srsw_pkg::t_action              r_out_action, n_out_action;
    logic [srsw_pkg::SEQ_NUM_W-1:0] r_out_seq, n_out_seq;
    logic                           r_out_last, n_out_last;

    logic [SEQ_W-1:0] w_seq_tab [TAB_N];
    logic [SEQ_W:0]   w_dist_x;
    logic [CMP_W-1:0] w_dist;
    logic [CMP_W-1:0] w_win;
    logic             w_grant;
    logic             w_walk_more;
    logic             w_out_free;

    // Reduce an incoming number into the sequence space
    for (genvar g = 0; g < TAB_N; g++) begin : g_seq_tab
        assign w_seq_tab[g] = SEQ_W'(g % SEQ_SPACE);
    end

    // Window room: modular distance from base to next against the clamped size
    assign w_dist_x = {1'b0, r_next} - {1'b0, r_base} + ((r_next < r_base) ? SEQ_SPAN : '0);
    assign w_dist   = CMP_W'(w_dist_x[SEQ_W-1:0]);
    assign w_win    = (CMP_W'(r_window_size) > WIN_MAX) ? WIN_MAX : CMP_W'(r_window_size);
    assign w_grant  = (w_dist < w_win);

    assign w_walk_more = r_rd_mark && (r_walked != srsw_pkg::MAX_WALK);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_status.clear_done = (r_clr_addr == SEQ_LAST);
    assign o_status.out_free   = w_out_free;
    assign o_status.req        = r_req;
    assign o_status.at_base    = (r_seq == r_base);
    assign o_status.walk_more  = w_walk_more;

    // Carry out the operation chosen by the controller
    always_comb begin
        n_base       = r_base;
        n_next       = r_next;
        n_cur        = r_cur;
        n_seq        = r_seq;
        n_clr_addr   = r_clr_addr;
        n_walked     = r_walked;
        n_req        = r_req;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_action = r_out_action;
        n_out_seq    = r_out_seq;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_base;
        w_wr_data    = 1'b0;
        case (i_cmd.op)
            srsw_pkg::DP_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                n_clr_addr = seq_inc(r_clr_addr);
            end
            srsw_pkg::DP_LOAD: begin
                n_req = srsw_pkg::t_req'(i_in_req);
                n_seq = w_seq_tab[i_in_seq];
            end
            srsw_pkg::DP_SEND: begin
                n_out_valid  = 1'b1;
                n_out_action = w_grant ? srsw_pkg::ACT_GRANT : srsw_pkg::ACT_REFUSE;
                n_out_seq    = seq_out(r_next);
                n_out_last   = 1'b1;
                if (w_grant) begin
                    n_next = seq_inc(r_next);
                end
            end
            srsw_pkg::DP_NACK: begin
                n_out_valid  = 1'b1;
                n_out_action = srsw_pkg::ACT_RETX;
                n_out_seq    = seq_out(r_seq);
                n_out_last   = 1'b1;
            end
            srsw_pkg::DP_MARK: begin
                w_wr_en      = 1'b1;
                w_wr_addr    = r_seq;
                w_wr_data    = 1'b1;
                n_out_valid  = 1'b1;
                n_out_action = srsw_pkg::ACT_STOP;
                n_out_seq    = seq_out(r_seq);
                n_out_last   = 1'b1;
            end
            srsw_pkg::DP_BASE: begin
                // Clear the base mark, park its stop and look at the next entry
                w_wr_en  = 1'b1;
                w_wr_addr = r_base;
                n_cur    = r_base;
                n_base   = seq_inc(r_base);
                n_walked = '0;
            end
            srsw_pkg::DP_WALK: begin
                n_out_valid  = 1'b1;
                n_out_action = srsw_pkg::ACT_STOP;
                n_out_seq    = seq_out(r_cur);
                n_out_last   = !w_walk_more;
                if (w_walk_more) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_base;
                    n_cur     = r_base;
                    n_base    = seq_inc(r_base);
                    n_walked  = r_walked + srsw_pkg::WALK_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= srsw_pkg::WIN_RESET;
            r_base        <= SEQ_W'(1);
            r_next        <= SEQ_W'(1);
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_size <= i_cfg_data;
            end
            r_base      <= n_base;
            r_next      <= n_next;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold working and result payload
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_seq        <= n_seq;
        r_walked     <= n_walked;
        r_req        <= n_req;
        r_out_action <= n_out_action;
        r_out_seq    <= n_out_seq;
        r_out_last   <= n_out_last;
    end

    // Mark memory: one write port, registered read of the coming base
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_marks[w_wr_addr] <= w_wr_data;
        end
        r_rd_mark <= r_marks[n_base];
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_action = r_out_action;
    assign o_out_seq    = r_out_seq;
    assign o_out_last   = r_out_last;

endmodule

/* hdl/selective_repeat_send_window_core.sv */
// Sender window for selective-repeat ARQ. After reset the block sweeps its
// acknowledged-mark memory clear, one entry per cycle, and holds
// o_s_axis_tready low meanwhile; configuration writes are taken at any time.
// Items are handled one at a time: a send request, a NACK or an ACK away from
// the window base is accepted, then executed into the result register once
// that is free; an unused request kind is accepted, then dropped. An ACK at
// the base is accepted, then clears the base mark and walks the marked entries
// behind it; the walk reads one mark from the mark memory per cycle while the
// master side takes results, and emits one stop-timer transfer per entry. A
// waiting result does not stop the next item from being accepted.
module selective_repeat_send_window_core #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: window_size
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srsw_pkg::WIN_W-1:0]        i_cfg_data,
    // Request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [srsw_pkg::DATA_W-1:0]       i_s_axis_tdata,   // [5:0] seq_number
    input  logic [srsw_pkg::REQ_W-1:0]        i_s_axis_tuser,   // [1:0] req_type
    // Action stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [srsw_pkg::DATA_W-1:0]       o_m_axis_tdata,   // [5:0] action_seq
    output logic [srsw_pkg::ACT_W-1:0]        o_m_axis_tuser,   // [1:0] action
    output logic                              o_m_axis_tlast
);

    srsw_pkg::t_dp_cmd              w_cmd;
    srsw_pkg::t_dp_status           w_status;
    logic [srsw_pkg::SEQ_NUM_W-1:0] w_out_seq;

    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    srsw_datapath #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_req     (i_s_axis_tuser),
        .i_in_seq     (i_s_axis_tdata[srsw_pkg::SEQ_NUM_W-1:0]),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_action (o_m_axis_tuser),
        .o_out_seq    (w_out_seq),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = w_cmd.in_ready;
    assign o_m_axis_tdata  = {{(srsw_pkg::DATA_W - srsw_pkg::SEQ_NUM_W){1'b0}}, w_out_seq};

endmodule

/* hdl/srsw_checker.sv */
module srsw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [srsw_pkg::WIN_W-1:0]   i_cfg_data,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic [srsw_pkg::DATA_W-1:0]  i_s_axis_tdata,
    input logic [srsw_pkg::REQ_W-1:0]   i_s_axis_tuser,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [srsw_pkg::DATA_W-1:0]  o_m_axis_tdata,
    input logic [srsw_pkg::ACT_W-1:0]   o_m_axis_tuser,
    input logic                         o_m_axis_tlast
);

    // No result is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted back to back");

    // Only a stop-timer result can be followed by more results for the same item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != srsw_pkg::ACT_STOP |-> o_m_axis_tlast)
        else $error("non-stop result without tlast");

    // While a non-final result waits, the walk is still running and no request is taken
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("request accepted during a walk");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind selective_repeat_send_window_core srsw_checker u_srsw_checker (.*);

/* test/testbench.sv */
module testbench;

    // Request kind that the block takes and drops without any result
    localparam logic [srsw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    // One action transfer as the block should emit it
    typedef struct packed {
        srsw_pkg::t_action act;
        logic [5:0]        seq;
        logic              last;
    } t_window_action;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [srsw_pkg::WIN_W-1:0]      cfg_data = '0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    logic [srsw_pkg::DATA_W-1:0]     req_data = '0;
    logic [srsw_pkg::REQ_W-1:0]      req_kind = srsw_pkg::REQ_SEND;
    logic                            act_valid;
    logic                            act_ready = 1'b0;
    logic [srsw_pkg::DATA_W-1:0]     act_data;
    logic [srsw_pkg::ACT_W-1:0]      act_kind;
    logic                            act_last;

    // Predicted window state
    logic [srsw_pkg::WIN_W-1:0]      win_size;
    logic [5:0]                      win_base;
    logic [5:0]                      next_seq;
    logic                            acked [64];

    t_window_action        expected_actions [$];
    t_window_action        got_action;
    t_window_action        want_action;
    int                    fail_count = 0;
    int                    burst_left = 0;
    int                    quiet_cycles = 0;
    int                    rx_mode = 0;
    int                    rx_left = 0;

    selective_repeat_send_window_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_kind),
        .o_m_axis_tvalid (act_valid),
        .i_m_axis_tready (act_ready),
        .o_m_axis_tdata  (act_data),
        .o_m_axis_tuser  (act_kind),
        .o_m_axis_tlast  (act_last)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Work out the actions one accepted request causes and advance the window
    task automatic predict_actions(input logic [srsw_pkg::REQ_W-1:0] kind,
                                   input logic [5:0] seq);
        logic [5:0] span;
        int         walked;
        span   = next_seq - win_base;
        walked = 0;
        case (kind)
            srsw_pkg::REQ_SEND: begin
                // a 6-bit window can never exceed SEQ_SPACE - 1, so no clamp is needed
                if (span < win_size) begin
                    expected_actions.push_back('{srsw_pkg::ACT_GRANT, next_seq, 1'b1});
                    next_seq = next_seq + 6'd1;
                end else begin
                    expected_actions.push_back('{srsw_pkg::ACT_REFUSE, next_seq, 1'b1});
                end
            end
            srsw_pkg::REQ_ACK: begin
                if (seq == win_base) begin
                    acked[win_base] = 1'b0;
                    expected_actions.push_back('{srsw_pkg::ACT_STOP, win_base, 1'b0});
                    win_base = win_base + 6'd1;
                    while (acked[win_base] && walked < 63) begin
                        acked[win_base] = 1'b0;
                        expected_actions.push_back('{srsw_pkg::ACT_STOP, win_base, 1'b0});
                        win_base = win_base + 6'd1;
                        walked++;
                    end
                    expected_actions[expected_actions.size()-1].last = 1'b1;
                end else begin
                    acked[seq] = 1'b1;
                    expected_actions.push_back('{srsw_pkg::ACT_STOP, seq, 1'b1});
                end
            end
            srsw_pkg::REQ_NACK: begin
                expected_actions.push_back('{srsw_pkg::ACT_RETX, seq, 1'b1});
            end
            default: begin
            end
        endcase
    endtask

    // Offer one request in bursts with random gaps; keep tvalid up for the next one
    task automatic send_request(input logic [srsw_pkg::REQ_W-1:0] kind,
                                input logic [5:0] seq);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_valid <= 1'b1;
        req_data  <= {2'b00, seq};
        req_kind  <= kind;
        do @(posedge clk); while (!req_ready);
        burst_left--;
        predict_actions(kind, seq);
    endtask

    // Hold the request side until every expected action has been transferred
    task automatic drain_actions();
        req_valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the window size register; only called while the block is idle
    task automatic write_window(input logic [srsw_pkg::WIN_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do @(posedge clk); while (!cfg_ready);
        win_size = size;
        cfg_valid <= 1'b0;
    endtask

    task automatic note_failure(input string what, input t_window_action want,
                                input t_window_action got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch (%s): expected act=%0d seq=%0d last=%0d, %s%0d %s%0d %s%0d",
                     what, want.act, want.seq, want.last,
                     "got act=", got.act, "seq=", got.seq, "last=", got.last);
    endtask

    // Reset window of eight: eight grants from one, then a refusal
    task automatic test_reset_window();
        repeat (9) send_request(srsw_pkg::REQ_SEND, 6'd0);
    endtask

    // Marks, a walk from the base, an ACK outside the window, NACKs, dropped kind
    task automatic test_ack_nack();
        send_request(srsw_pkg::REQ_ACK, 6'd3);
        send_request(srsw_pkg::REQ_ACK, 6'd2);
        send_request(srsw_pkg::REQ_ACK, 6'd1);
        send_request(srsw_pkg::REQ_ACK, 6'd63);
        send_request(srsw_pkg::REQ_ACK, 6'd4);
        send_request(srsw_pkg::REQ_NACK, 6'd0);
        send_request(srsw_pkg::REQ_NACK, 6'd63);
        send_request(REQ_UNUSED, 6'd63);
        send_request(REQ_UNUSED, 6'd0);
        drain_actions();
    endtask

    // Window of zero refuses everything; widest window grants
    task automatic test_window_limits();
        write_window(6'd0);
        send_request(srsw_pkg::REQ_SEND, 6'd63);
        send_request(srsw_pkg::REQ_SEND, 6'd0);
        drain_actions();
        write_window(6'd63);
        send_request(srsw_pkg::REQ_SEND, 6'd0);
        drain_actions();
    endtask

    // Mark every entry but the base in shuffled order, then ACK the base
    task automatic test_long_walk();
        logic [5:0] order [63];
        logic [5:0] swap;
        int         n;
        int         j;
        n = 0;
        for (int s = 0; s < 64; s++)
            if (6'(s) != win_base) begin
                order[n] = 6'(s);
                n++;
            end
        for (int i = 62; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < 63; i++)
            send_request(srsw_pkg::REQ_ACK, order[i]);
        send_request(srsw_pkg::REQ_ACK, win_base);
        drain_actions();
    endtask

    // Mostly sends and ACKs of outstanding numbers, with noise mixed in
    task automatic test_random_traffic(input logic [srsw_pkg::WIN_W-1:0] size,
                                       input int count);
        logic [5:0] span;
        logic [5:0] seq;
        int         pick;
        int         issued;
        write_window(size);
        issued = 0;
        while (issued < count) begin
            span = next_seq - win_base;
            pick = $urandom_range(0, 99);
            seq  = 6'($urandom_range(0, 63));
            if (pick < 35 || (pick < 65 && span == 0)) begin
                send_request(srsw_pkg::REQ_SEND, seq);
            end else if (pick < 65) begin
                send_request(srsw_pkg::REQ_ACK, win_base + 6'($urandom_range(0, span - 1)));
            end else if (pick < 76) begin
                send_request(srsw_pkg::REQ_ACK, win_base);
            end else if (pick < 87) begin
                send_request(srsw_pkg::REQ_NACK, seq);
            end else if (pick < 95) begin
                send_request(srsw_pkg::REQ_ACK, seq);
            end else begin
                send_request(REQ_UNUSED, seq);
                issued--;
            end
            issued++;
            if ($urandom_range(0, 63) == 0)
                drain_actions();
        end
        drain_actions();
    endtask

    // Receiver: switch between stall patterns of random length
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(8, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: begin
                act_ready <= 1'b1;
            end
            1: begin
                act_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                act_ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                act_ready <= (rx_left % 5 >= 2);
            end
        endcase
    end

    // Compare each transferred action with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && act_valid && act_ready) begin
            got_action = '{srsw_pkg::t_action'(act_kind), act_data[5:0], act_last};
            if (expected_actions.size() == 0) begin
                note_failure("no action expected", '0, got_action);
            end else begin
                want_action = expected_actions.pop_front();
                if (got_action != want_action)
                    note_failure("field", want_action, got_action);
            end
        end
    end

    // End the run when nothing is transferred for too long
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (act_valid && act_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[selective_repeat_send_window_core] ERROR");
            $finish;
        end
    end

    initial begin
        win_size = srsw_pkg::WIN_RESET;
        win_base = 6'd1;
        next_seq = 6'd1;
        for (int s = 0; s < 64; s++)
            acked[s] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_ack_nack();
        test_window_limits();
        test_long_walk();
        test_random_traffic(6'd1, 60);
        test_random_traffic(6'd63, 70);
        test_random_traffic(6'($urandom_range(2, 62)), 70);
        test_random_traffic(6'd0, 20);
        test_random_traffic(6'($urandom_range(2, 16)), 80);

        if (fail_count == 0 && expected_actions.size() == 0)
            $display("[selective_repeat_send_window_core] OK");
        else
            $display("[selective_repeat_send_window_core] ERROR");
        $finish;
    end

endmodule
